// File: hdl/apdac_pkg.sv
package apdac_pkg;

  localparam int MODE_PACE     = 0;
  localparam int MODE_CONTROL  = 1;
  localparam int MODE_ONLY_NEG = 2;
  localparam int MODE_CONTINUE = 3;
  localparam int MODE_AUTOGAIN = 4;

  localparam logic [2:0] REG_NOMINAL  = 3'd0;
  localparam logic [2:0] REG_FRACTION = 3'd1;
  localparam logic [2:0] REG_GAIN     = 3'd2;
  localparam logic [2:0] REG_STEP     = 3'd3;
  localparam logic [2:0] REG_MODE     = 3'd4;

  localparam logic [15:0] NOMINAL_RST  = 16'd500;
  localparam logic [9:0]  FRACTION_RST = 10'd102;
  localparam logic [15:0] GAIN_RST     = 16'd2048;
  localparam logic [11:0] STEP_RST     = 12'd41;
  localparam logic [4:0]  MODE_RST     = 5'd4;
  localparam logic [3:0]  HIST_RST     = 4'b0101;

  // result of the per-beat control update
  typedef struct packed {
    logic signed [15:0] pert;
    logic               arm;
    logic [3:0]         hist;
    logic [15:0]        gain;
  } ctl_t;

endpackage

// File: hdl/apdac_ctl.sv
module apdac_ctl (
  input  logic [15:0] duration_before,
  input  logic [15:0] duration_last,
  input  logic [15:0] gain,
  input  logic [11:0] gain_step,
  input  logic [4:0]  mode_flags,
  input  logic [3:0]  hist,
  output apdac_pkg::ctl_t res
);

  logic signed [16:0] diff;
  logic signed [33:0] prod;
  logic signed [33:0] prod_adj;
  logic signed [21:0] quot;
  logic signed [22:0] neg;
  logic signed [15:0] d;
  logic               bit_in;
  logic [3:0]         hist_n;
  logic [17:0]        gain_up;
  logic [16:0]        gain_dn;

  always_comb begin
    diff = $signed({1'b0, duration_before}) - $signed({1'b0, duration_last});
    prod = $signed({1'b0, gain}) * diff;
    // truncate toward zero on the shift
    prod_adj = prod + (prod[33] ? 34'sd4095 : 34'sd0);
    quot = prod_adj[33:12];
    neg = -{quot[21], quot};
    if (neg > 23'sd32767) begin
      d = 16'sh7fff;
    end else if (neg < -23'sd32768) begin
      d = -16'sh8000;
    end else begin
      d = neg[15:0];
    end
    res.pert = d;
    res.arm = !mode_flags[apdac_pkg::MODE_ONLY_NEG] || d[15];
    bit_in = !res.arm;
    hist_n = {bit_in, hist[3:1]};
    res.hist = hist_n;
    gain_up = {2'b0, gain} + {6'b0, gain_step};
    gain_dn = {1'b0, gain} - {5'b0, gain_step};
    if (!mode_flags[apdac_pkg::MODE_AUTOGAIN]) begin
      res.gain = gain;
    end else if (hist_n == 4'b0101 || hist_n == 4'b1010) begin
      res.gain = (gain_up > 18'd65535) ? 16'hffff : gain_up[15:0];
    end else begin
      res.gain = gain_dn[16] ? 16'd0 : gain_dn[15:0];
    end
  end

endmodule

// File: hdl/apd_alternans_pacing_control.sv
// One sample per transaction, one result per sample, in order.
// The input transaction loads the sample into the input register; the result is
// loaded into the result register when that register is free and is offered from then on.
// Throughput: one sample per cycle while results are accepted; the per-sample
// update is one pass of logic between the input register and the result register.
// A stalled result holds one more sample in the input register, after which
// s_tready drops. Reset (rst, synchronous): both stages empty, all state and
// configuration registers to their defaults.
module apd_alternans_pacing_control #(
  parameter int PEAK_WINDOW = 25,
  parameter int PULSE_WIDTH = 2,
  parameter int SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // sample_voltage, threshold_crossed, zero fill
  input  logic [((SAMPLE_BITS + 8) / 8) * 8 - 1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // stimulus_active, beat_done, duration_scans, diastolic_scans,
  // perturbation, gain_now, zero fill
  output logic [71:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SB  = SAMPLE_BITS;
  localparam int WCW = $clog2(PEAK_WINDOW + 1);
  localparam int PCW = $clog2(PULSE_WIDTH + 1);
  localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic [WCW-1:0] WIN_END = WCW'(PEAK_WINDOW);
  localparam logic [PCW-1:0] PW = PCW'(PULSE_WIDTH);
  localparam logic signed [PCW:0] CPW = (PCW+1)'(PULSE_WIDTH);

  logic [15:0] nominal_interval;
  logic [9:0]  repol_fraction;
  logic [11:0] gain_step;
  logic [4:0]  mode_flags;

  logic                 in_valid;
  logic signed [SB-1:0] in_v;
  logic                 in_crossed;
  logic                 adv;

  logic [31:0]          scan_count;
  logic signed [SB-1:0] baseline_running, baseline_prev, baseline_prev2, peak_level;
  logic signed [SB+1:0] repol_level;
  logic [WCW-1:0]       window_count;
  logic [31:0]          beat_start, beat_end;
  logic [15:0]          duration_last, duration_before, diastolic_last;
  logic [16:0]          pace_interval_count;
  logic [PCW-1:0]       pace_pulse_count;
  logic                 control_pending;
  logic signed [17:0]   control_interval_count;
  logic signed [PCW:0]  control_pulse_count;
  logic signed [15:0]   perturb_last;
  logic [3:0]           sign_history;
  logic [15:0]          gain_value;
  logic                 stim_level;

  logic signed [SB-1:0] baseline_running_next, baseline_prev_next, baseline_prev2_next;
  logic signed [SB-1:0] peak_level_next;
  logic signed [SB+1:0] repol_level_next;
  logic [WCW-1:0]       window_count_next;
  logic [31:0]          beat_start_next, beat_end_next;
  logic [15:0]          duration_last_next, duration_before_next, diastolic_last_next;
  logic [16:0]          pace_interval_count_next;
  logic [PCW-1:0]       pace_pulse_count_next;
  logic                 control_pending_next;
  logic signed [17:0]   control_interval_count_next;
  logic signed [PCW:0]  control_pulse_count_next;
  logic signed [15:0]   perturb_last_next;
  logic [3:0]           sign_history_next;
  logic [15:0]          gain_value_next;
  logic                 stim_level_next;
  logic                 done;
  logic                 win_close;

  logic signed [SB-1:0]  base;
  logic signed [SB:0]    amp;
  logic signed [SB+11:0] rprod, rprod_adj;
  logic [31:0]           di_raw, apd_raw;
  logic [15:0]           apd_sat;
  logic signed [17:0]    cic_arm;
  apdac_pkg::ctl_t       ctl;

  assign adv = !m_tvalid || m_tready;
  assign s_tready = !in_valid || adv;

  // fed with the durations a beat end would produce, used only when one does
  apdac_ctl u_ctl (
    .duration_before (duration_last),
    .duration_last   (apd_sat),
    .gain            (gain_value),
    .gain_step       (gain_step),
    .mode_flags      (mode_flags),
    .hist            (sign_history),
    .res             (ctl)
  );

  always_comb begin
    stim_level_next = stim_level;
    pace_interval_count_next = pace_interval_count;
    pace_pulse_count_next = pace_pulse_count;
    // periodic pacing
    if (pace_interval_count == 17'd0 && mode_flags[apdac_pkg::MODE_PACE]) begin
      stim_level_next = 1'b1;
      pace_interval_count_next = {1'b0, nominal_interval};
      pace_pulse_count_next = PW;
    end
    if (pace_pulse_count_next == '0) stim_level_next = 1'b0;
    if (pace_interval_count_next != 17'd0) pace_interval_count_next = pace_interval_count_next - 17'd1;
    if (pace_pulse_count_next != '0) pace_pulse_count_next = pace_pulse_count_next - PCW'(1);

    // beat analysis
    baseline_running_next = (in_v < baseline_running) ? in_v : baseline_running;
    baseline_prev_next = baseline_prev;
    baseline_prev2_next = baseline_prev2;
    peak_level_next = peak_level;
    window_count_next = window_count;
    beat_start_next = beat_start;
    repol_level_next = repol_level;
    win_close = 1'b0;
    if (in_crossed) begin
      window_count_next = WCW'(1);
      beat_start_next = scan_count;
      baseline_prev2_next = baseline_prev;
      baseline_prev_next = baseline_running_next;
      baseline_running_next = SMAX;
      peak_level_next = SMIN;
    end
    base = (baseline_prev2_next > baseline_prev_next) ? baseline_prev2_next
                                                       : baseline_prev_next;
    if (window_count_next != '0 && window_count_next < WIN_END) begin
      if (in_v > peak_level_next) peak_level_next = in_v;
      window_count_next = window_count_next + WCW'(1);
      win_close = (window_count_next == WIN_END);
    end
    amp = {peak_level_next[SB-1], peak_level_next} - {base[SB-1], base};
    rprod = $signed({1'b0, repol_fraction}) * amp;
    rprod_adj = rprod + (rprod[SB+11] ? (SB+12)'(1023) : (SB+12)'(0));
    if (win_close) begin
      repol_level_next = {{2{base[SB-1]}}, base} + rprod_adj[SB+11:10];
    end

    done = 1'b0;
    duration_before_next = duration_before;
    duration_last_next = duration_last;
    diastolic_last_next = diastolic_last;
    beat_end_next = beat_end;
    di_raw = beat_start_next - beat_end;
    apd_raw = scan_count - beat_start_next;
    apd_sat = (apd_raw[31:16] != 16'd0) ? 16'hffff : apd_raw[15:0];
    if (window_count_next == WIN_END &&
        $signed({{2{in_v[SB-1]}}, in_v}) < repol_level_next) begin
      done = 1'b1;
      window_count_next = '0;
      duration_before_next = duration_last;
      diastolic_last_next = (di_raw[31:16] != 16'd0) ? 16'hffff : di_raw[15:0];
      beat_end_next = scan_count;
      duration_last_next = apd_sat;
    end

    perturb_last_next = perturb_last;
    sign_history_next = sign_history;
    gain_value_next = gain_value;
    control_pending_next = control_pending;
    control_interval_count_next = control_interval_count;
    cic_arm = $signed({1'b0, pace_interval_count_next}) + 18'(ctl.pert);
    if (done && mode_flags[apdac_pkg::MODE_CONTROL]) begin
      perturb_last_next = ctl.pert;
      sign_history_next = ctl.hist;
      gain_value_next = ctl.gain;
      if (ctl.arm) begin
        control_pending_next = 1'b1;
        control_interval_count_next = cic_arm;
        if (ctl.pert > 16'sd0 && !mode_flags[apdac_pkg::MODE_CONTINUE]) begin
          pace_interval_count_next = 17'(cic_arm + 18'sd1);
        end
      end
    end

    // control stimulus
    control_pulse_count_next = control_pulse_count;
    if (control_pending_next) begin
      if (control_interval_count_next == 18'sd0) begin
        stim_level_next = 1'b1;
        control_pulse_count_next = CPW;
        if (!mode_flags[apdac_pkg::MODE_CONTINUE]) begin
          pace_interval_count_next = {1'b0, nominal_interval};
        end
      end
      if (control_pulse_count_next == '0) begin
        stim_level_next = 1'b0;
        control_pending_next = 1'b0;
      end
      if (control_interval_count_next >= 18'sd0) begin
        control_interval_count_next = control_interval_count_next - 18'sd1;
      end
      // counts down to -1 and rests there
      if (!control_pulse_count_next[PCW]) begin
        control_pulse_count_next = control_pulse_count_next - (PCW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_v <= s_tdata[SB-1:0];
      in_crossed <= s_tdata[SB];
    end
    if (in_valid && adv) begin
      m_tdata <= {6'd0, gain_value_next, perturb_last_next, diastolic_last_next,
                  duration_last_next, done, stim_level_next};
    end
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
      nominal_interval <= apdac_pkg::NOMINAL_RST;
      repol_fraction <= apdac_pkg::FRACTION_RST;
      gain_step <= apdac_pkg::STEP_RST;
      mode_flags <= apdac_pkg::MODE_RST;
      scan_count <= '0;
      baseline_running <= SMAX;
      baseline_prev <= SMAX;
      baseline_prev2 <= SMAX;
      peak_level <= SMIN;
      repol_level <= '0;
      window_count <= '0;
      beat_start <= '0;
      beat_end <= '0;
      duration_last <= '0;
      duration_before <= '0;
      diastolic_last <= '0;
      pace_interval_count <= '0;
      pace_pulse_count <= '0;
      control_pending <= 1'b0;
      control_interval_count <= '0;
      control_pulse_count <= '1;
      perturb_last <= '0;
      sign_history <= apdac_pkg::HIST_RST;
      gain_value <= apdac_pkg::GAIN_RST;
      stim_level <= 1'b0;
    end else begin
      if (s_tready) in_valid <= s_tvalid;
      if (adv) m_tvalid <= in_valid;
      if (in_valid && adv) begin
        scan_count <= scan_count + 32'd1;
        baseline_running <= baseline_running_next;
        baseline_prev <= baseline_prev_next;
        baseline_prev2 <= baseline_prev2_next;
        peak_level <= peak_level_next;
        repol_level <= repol_level_next;
        window_count <= window_count_next;
        beat_start <= beat_start_next;
        beat_end <= beat_end_next;
        duration_last <= duration_last_next;
        duration_before <= duration_before_next;
        diastolic_last <= diastolic_last_next;
        pace_interval_count <= pace_interval_count_next;
        pace_pulse_count <= pace_pulse_count_next;
        control_pending <= control_pending_next;
        control_interval_count <= control_interval_count_next;
        control_pulse_count <= control_pulse_count_next;
        perturb_last <= perturb_last_next;
        sign_history <= sign_history_next;
        gain_value <= gain_value_next;
        stim_level <= stim_level_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          apdac_pkg::REG_NOMINAL:  nominal_interval <= cfg_data;
          apdac_pkg::REG_FRACTION: repol_fraction <= cfg_data[9:0];
          // gain_initial only matters as the value loaded into the gain
          apdac_pkg::REG_GAIN:     gain_value <= cfg_data;
          apdac_pkg::REG_STEP:     gain_step <= cfg_data[11:0];
          apdac_pkg::REG_MODE:     mode_flags <= cfg_data[4:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: hdl/apdac_chk.sv
module apdac_chk #(
  parameter int SAMPLE_BITS = 16
) (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic [((SAMPLE_BITS + 8) / 8) * 8 - 1:0] s_tdata,
  input logic m_tvalid,
  input logic m_tready,
  input logic [71:0] m_tdata,
  input logic cfg_we,
  input logic [2:0] cfg_index,
  input logic [15:0] cfg_data
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with output empty");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && !$past(s_tvalid && s_tready) && !$past(rst) |=> !m_tvalid)
    else $error("result without transaction");

endmodule

bind apd_alternans_pacing_control apdac_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_apdac_chk (.*);

// File: test/tb_top.sv
module tb_top;

  localparam int PEAK_W     = 25;
  localparam int PULSE_W    = 2;
  localparam int LIMIT      = 400000;
  localparam int HOLD_LEN   = 300;

  typedef struct packed {
    logic               stim;
    logic               done;
    logic [15:0]        dur;
    logic [15:0]        di;
    logic signed [15:0] pert;
    logic [15:0]        gain;
  } beat_res_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [71:0] m_tdata;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  apd_alternans_pacing_control dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // predictor state
  logic [15:0] r_nom, r_gain0;
  logic [9:0]  r_frac;
  logic [11:0] r_step;
  logic [4:0]  r_mode;
  int unsigned scan, bstart, bend, win, dur_last, dur_bef, di_last;
  longint      base_run, base_p, base_p2, peak, repol;
  longint      pace_cnt, ctl_cnt, pert_last, gain;
  int          pace_pulse, ctl_pulse;
  bit          ctl_pend, stim;
  logic [3:0]  hist;

  beat_res_t   beat_q[$];
  int          errors = 0, cycles = 0, n_items = 0, n_beats = 0, n_stims = 0;
  bit          calm = 0, hold_go = 0;
  int          hold_left = 0;

  function automatic int unsigned sat16(int unsigned d);
    return d > 65535 ? 65535 : d;
  endfunction

  function automatic void reset_model();
    r_nom = apdac_pkg::NOMINAL_RST; r_frac = apdac_pkg::FRACTION_RST;
    r_gain0 = apdac_pkg::GAIN_RST;
    r_step = apdac_pkg::STEP_RST; r_mode = apdac_pkg::MODE_RST;
    scan = 0; bstart = 0; bend = 0; win = 0; dur_last = 0; dur_bef = 0; di_last = 0;
    base_run = 32767; base_p = 32767; base_p2 = 32767; peak = -32768; repol = 0;
    pace_cnt = 0; pace_pulse = 0; ctl_pend = 0; ctl_cnt = 0; ctl_pulse = -1;
    pert_last = 0; hist = apdac_pkg::HIST_RST; gain = apdac_pkg::GAIN_RST; stim = 0;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      apdac_pkg::REG_NOMINAL:  r_nom = val;
      apdac_pkg::REG_FRACTION: r_frac = val[9:0];
      apdac_pkg::REG_GAIN: begin
        r_gain0 = val;
        gain = val;
      end
      apdac_pkg::REG_STEP:     r_step = val[11:0];
      apdac_pkg::REG_MODE:     r_mode = val[4:0];
      default: ;
    endcase
  endfunction

  function automatic beat_res_t scan_update(logic signed [15:0] sv, bit cr);
    longint    v, b, diff, d;
    bit        done, nb;
    beat_res_t r;
    v = sv;
    done = 0;
    if (pace_cnt == 0 && r_mode[apdac_pkg::MODE_PACE]) begin
      stim = 1;
      pace_cnt = r_nom;
      pace_pulse = PULSE_W;
    end
    if (pace_pulse == 0) stim = 0;
    if (pace_cnt > 0) pace_cnt--;
    if (pace_pulse > 0) pace_pulse--;

    if (v < base_run) base_run = v;
    if (cr) begin
      win = 1; bstart = scan;
      base_p2 = base_p; base_p = base_run;
      base_run = 32767; peak = -32768;
    end
    if (win != 0 && win < PEAK_W) begin
      if (v > peak) peak = v;
      win++;
      if (win == PEAK_W) begin
        b = base_p > base_p2 ? base_p : base_p2;
        repol = b + (longint'(r_frac) * (peak - b)) / 1024;
      end
    end
    if (win == PEAK_W && v < repol) begin
      done = 1; win = 0;
      dur_bef = dur_last;
      di_last = sat16(bstart - bend);
      bend = scan;
      dur_last = sat16(bend - bstart);
      if (r_mode[apdac_pkg::MODE_CONTROL]) begin
        diff = longint'(dur_bef) - longint'(dur_last);
        d = -((gain * diff) / 4096);
        if (d > 32767) d = 32767;
        if (d < -32768) d = -32768;
        pert_last = d;
        if (!r_mode[apdac_pkg::MODE_ONLY_NEG] || d <= -1) begin
          ctl_pend = 1;
          ctl_cnt = pace_cnt + d;
          if (d >= 1 && !r_mode[apdac_pkg::MODE_CONTINUE]) pace_cnt = ctl_cnt + 1;
          nb = 0;
        end else begin
          nb = 1;
        end
        hist = {nb, hist[3:1]};
        if (r_mode[apdac_pkg::MODE_AUTOGAIN]) begin
          if (hist == 4'b0101 || hist == 4'b1010) begin
            gain = gain + r_step;
            if (gain > 65535) gain = 65535;
          end else begin
            gain = gain - r_step;
            if (gain < 0) gain = 0;
          end
        end
      end
    end

    if (ctl_pend) begin
      if (ctl_cnt == 0) begin
        stim = 1;
        ctl_pulse = PULSE_W;
        if (!r_mode[apdac_pkg::MODE_CONTINUE]) pace_cnt = r_nom;
      end
      if (ctl_pulse == 0) begin
        stim = 0;
        ctl_pend = 0;
      end
      if (ctl_cnt >= 0) ctl_cnt--;
      if (ctl_pulse >= 0) ctl_pulse--;
    end
    scan++;

    r.stim = stim; r.done = done; r.dur = dur_last[15:0]; r.di = di_last[15:0];
    r.pert = pert_last[15:0]; r.gain = gain[15:0];
    return r;
  endfunction

  task automatic send_sample(logic signed [15:0] sv, bit cr);
    if (!calm && $urandom_range(99) < 8) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {7'b0, cr, sv};
    do @(posedge clk); while (!s_tready);
    beat_q.push_back(scan_update(sv, cr));
    n_items++;
  endtask

  // stop offering and let the block drain before touching registers
  task automatic wait_idle();
    s_tvalid <= 0;
    @(posedge clk);
    while (beat_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic wr_reg(logic [2:0] idx, logic [15:0] val);
    wait_idle();
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    apply_reg(idx, val);
  endtask

  task automatic set_all(logic [15:0] nom, logic [15:0] frac, logic [15:0] g0,
                         logic [15:0] stp, logic [15:0] mode);
    wr_reg(apdac_pkg::REG_NOMINAL, nom);
    wr_reg(apdac_pkg::REG_FRACTION, frac);
    wr_reg(apdac_pkg::REG_GAIN, g0);
    wr_reg(apdac_pkg::REG_STEP, stp);
    wr_reg(apdac_pkg::REG_MODE, mode);
  endtask

  // one action potential: rest, upstroke, peak window, plateau, fall
  task automatic run_beat(int plateau);
    int pk, lo;
    repeat ($urandom_range(1, 8))
      send_sample(16'(-int'($urandom_range(10000, 20000))), 1'b0);
    pk = $urandom_range(5000, 32767);
    send_sample(16'(pk), 1'b1);
    repeat (PEAK_W - 2) begin
      lo = pk - int'($urandom_range(0, 4000));
      send_sample(16'(lo), $urandom_range(99) < 2);
    end
    repeat (plateau) send_sample(16'(pk), 1'b0);
    repeat ($urandom_range(1, 3))
      send_sample(16'(-int'($urandom_range(20001, 32768))), 1'b0);
  endtask

  task automatic random_config();
    case ($urandom_range(3))
      0: wr_reg(apdac_pkg::REG_NOMINAL, 16'($urandom_range(0, 80)));
      1: wr_reg(apdac_pkg::REG_FRACTION, 16'($urandom_range(0, 1023)));
      2: wr_reg(apdac_pkg::REG_GAIN, 16'($urandom_range(0, 65535)));
      default: wr_reg(apdac_pkg::REG_STEP, 16'($urandom_range(0, 4095)));
    endcase
    wr_reg(apdac_pkg::REG_MODE, 16'($urandom_range(0, 31)));
  endtask

  task automatic test_directed();
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh0000, 1'b0);
    set_all(16'd0, 16'd1023, 16'd65535, 16'd4095, 16'd31);
    run_beat(2);
    run_beat(0);
    set_all(16'd65535, 16'd0, 16'd0, 16'd0, 16'd0);
    run_beat(1);
  endtask

  task automatic test_control_modes();
    for (int m = 0; m < 32; m++) begin
      set_all(16'($urandom_range(1, 40)), 16'($urandom_range(0, 1023)),
              16'($urandom_range(1024, 65535)), 16'($urandom_range(0, 4095)), 16'(m));
      run_beat($urandom_range(0, 4));
    end
  endtask

  task automatic test_random();
    int start;
    start = n_items;
    while (n_items - start < 100) begin
      calm = (n_items - start > 20 && n_items - start < 80);
      if ($urandom_range(9) == 0) random_config();
      if ($urandom_range(4) == 0)
        repeat ($urandom_range(1, 10)) send_sample(16'($urandom), 1'($urandom_range(1)));
      else
        run_beat($urandom_range(0, 60));
    end
    calm = 0;
  endtask

  task automatic test_backpressure();
    calm = 1;
    hold_go = 1;
    repeat (2) run_beat($urandom_range(0, 30));
    calm = 0;
  endtask

  always @(posedge clk) begin
    if (hold_go) begin
      hold_go = 0;
      hold_left <= HOLD_LEN;
      m_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 0;
    end else begin
      m_tready <= calm || $urandom_range(99) >= 8;
    end
  end

  always @(posedge clk) begin
    beat_res_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got.stim = m_tdata[0]; got.done = m_tdata[1]; got.dur = m_tdata[17:2];
      got.di = m_tdata[33:18]; got.pert = m_tdata[49:34]; got.gain = m_tdata[65:50];
      if (beat_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        want = beat_q.pop_front();
        if (got.stim != want.stim) begin
          $error("stimulus_active exp %0d got %0d", want.stim, got.stim); errors++;
        end
        if (got.done != want.done) begin
          $error("beat_done exp %0d got %0d", want.done, got.done); errors++;
        end
        if (got.dur != want.dur) begin
          $error("duration_scans exp %0d got %0d", want.dur, got.dur); errors++;
        end
        if (got.di != want.di) begin
          $error("diastolic_scans exp %0d got %0d", want.di, got.di); errors++;
        end
        if (got.pert != want.pert) begin
          $error("perturbation exp %0d got %0d", want.pert, got.pert); errors++;
        end
        if (got.gain != want.gain) begin
          $error("gain_now exp %0d got %0d", want.gain, got.gain); errors++;
        end
        n_beats += want.done;
        n_stims += want.stim;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_control_modes();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (10) @(posedge clk);
    if (beat_q.size() != 0) begin
      $error("%0d results never arrived", beat_q.size());
      errors++;
    end
    $display("covered %0d samples, %0d beat ends, %0d stimulus scans, all 32 mode settings",
             n_items, n_beats, n_stims);
    $display("register extremes, random configs and a %0d-cycle output stall", HOLD_LEN);
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
